FILE: rtl/b64c_pkg.sv
package b64c_pkg;

  localparam int unsigned FifoDepth = 2;
  localparam logic [7:0] PadChar = 8'h3D;  // '='

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       final_char;
  } out_item_t;

  // One three-byte group ready for encoding. Count is 1..3 valid bytes.
  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  count;
    logic        fin;
  } group_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return 8'h5A - w;
    end else if (v < 6'd52) begin
      return w + 8'd71;
    end else if (v < 6'd62) begin
      return w - 8'd4;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

FILE: rtl/base64_encoder_custom_alphabet_top.sv
// Streaming base64 encoder with a permuted alphabet.
// Input channel src_*: one byte per transfer, final_byte set on the last
// byte of a message. Output channel enc_*: one ASCII character per transfer,
// final_char set on the last character of the message.
// Every third byte, and every byte flagged final, closes a group that yields
// four characters; a short final group is zero-filled and padded with '='.
// The front part collects bytes and hands closed groups to a two-entry queue;
// the back part turns one queued group into four characters, one per cycle
// while the receiver does not stall, into an output register.
// The first character of a group passes from the queue through the group
// register into the output register. Throughput: one character per cycle
// while the receiver does not stall, set by the back part, so sustained
// input is held back by src_stall when the queue fills.
// src_stall rises only while the queue is full.
// When the receiver stalls, the current character holds and the queue
// absorbs up to two further groups before the input stalls.
// Synchronous reset empties the queue and drops any held bytes.
module base64_encoder_custom_alphabet_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  b64c_pkg::in_item_t  src_data,
  output logic                enc_valid,
  input  logic                enc_stall,
  output b64c_pkg::out_item_t enc_data
);
  import b64c_pkg::*;

  logic   push;
  group_t push_data;
  logic   full;
  logic   pop;
  logic   empty;
  group_t head;

  b64c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  b64c_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  b64c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .enc_valid (enc_valid),
    .enc_stall (enc_stall),
    .enc_data  (enc_data)
  );

endmodule

FILE: rtl/b64c_front.sv
module b64c_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  b64c_pkg::in_item_t src_data,
  output logic               push,
  output b64c_pkg::group_t   push_data,
  input  logic               full
);
  import b64c_pkg::*;

  logic [15:0] held;
  logic [1:0]  held_cnt;
  logic [1:0]  n;
  logic        take;
  logic        emit;

  assign src_stall = full;
  assign take      = src_valid && !full;
  assign n         = held_cnt + 2'd1;
  assign emit      = src_data.final_byte || (n == 2'd3);
  assign push      = take && emit;

  always_comb begin
    unique case (held_cnt)
      2'd0:    push_data.triple = {src_data.in_byte, 16'h0000};
      2'd1:    push_data.triple = {held[7:0], src_data.in_byte, 8'h00};
      default: push_data.triple = {held, src_data.in_byte};
    endcase
    push_data.count = n;
    push_data.fin   = src_data.final_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      held_cnt <= '0;
    end else if (take) begin
      if (emit) begin
        held     <= '0;
        held_cnt <= '0;
      end else begin
        held     <= {held[7:0], src_data.in_byte};
        held_cnt <= n;
      end
    end
  end

endmodule

FILE: rtl/b64c_fifo.sv
module b64c_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64c_pkg::group_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output b64c_pkg::group_t head
);
  import b64c_pkg::*;

  group_t     slots [FifoDepth];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign full    = (fill == 2'(FifoDepth));
  assign empty   = (fill == 2'd0);
  assign head    = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: rtl/b64c_back.sv
module b64c_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  b64c_pkg::group_t    head,
  output logic                pop,
  output logic                enc_valid,
  input  logic                enc_stall,
  output b64c_pkg::out_item_t enc_data
);
  import b64c_pkg::*;

  group_t     grp;
  logic       grp_valid;
  logic [1:0] pos;
  logic       advance;
  logic [5:0] sextet;
  out_item_t  next_item;

  assign advance = grp_valid && (!enc_valid || !enc_stall);
  assign pop     = !empty && (!grp_valid || (advance && pos == 2'd3));

  always_comb begin
    unique case (pos)
      2'd0:    sextet = grp.triple[23:18];
      2'd1:    sextet = grp.triple[17:12];
      2'd2:    sextet = grp.triple[11:6];
      default: sextet = grp.triple[5:0];
    endcase
    // Positions past the number of valid bytes are padding.
    next_item.out_char   = (pos > grp.count) ? PadChar : sextet_char(sextet);
    next_item.final_char = grp.fin && (pos == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      grp <= head;
    end
    if (advance) begin
      enc_data <= next_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      pos       <= '0;
      enc_valid <= 1'b0;
    end else begin
      if (pop) begin
        grp_valid <= 1'b1;
      end else if (advance && pos == 2'd3) begin
        grp_valid <= 1'b0;
      end
      if (advance) begin
        pos       <= pos + 2'd1;
        enc_valid <= 1'b1;
      end else if (!enc_stall) begin
        enc_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/b64c_checker.sv
module b64c_checker (
  input logic                clk,
  input logic                rst,
  input logic                src_valid,
  input logic                src_stall,
  input b64c_pkg::in_item_t  src_data,
  input logic                enc_valid,
  input logic                enc_stall,
  input b64c_pkg::out_item_t enc_data
);
  import b64c_pkg::*;

  // Position of the next output character within its four-character group.
  logic [1:0] char_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_pos <= '0;
    end else if (enc_valid && !enc_stall) begin
      char_pos <= char_pos + 2'd1;
    end
  end

  a_src_hold: assert property (@(posedge clk) disable iff (rst)
    src_valid && src_stall |=> src_valid && $stable(src_data))
    else $error("stalled input byte changed or dropped");

  a_held_char: assert property (@(posedge clk) disable iff (rst)
    enc_valid && enc_stall |=> enc_valid && $stable(enc_data))
    else $error("stalled character changed or dropped");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !enc_valid)
    else $error("output valid right after reset");

  a_final_pos: assert property (@(posedge clk) disable iff (rst)
    enc_valid && enc_data.final_char |-> char_pos == 2'd3)
    else $error("final character not at end of a group");

  a_pad_pos: assert property (@(posedge clk) disable iff (rst)
    enc_valid && enc_data.out_char == PadChar |-> char_pos[1])
    else $error("padding in the first half of a group");

endmodule

bind base64_encoder_custom_alphabet_top b64c_checker u_b64c_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_stall (src_stall),
  .src_data  (src_data),
  .enc_valid (enc_valid),
  .enc_stall (enc_stall),
  .enc_data  (enc_data)
);
